### src/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Types and constants shared by the clock frame allocator modules.
// ----------------------------------------------------------------------------
package cfa_pkg;

    localparam int CFG_W  = 9;
    localparam int ACT_W  = 3;
    localparam int PAGE_W = 20;
    localparam int FI_W   = 8;
    localparam int STAT_W = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_TOUCH  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LOCK   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_UNLOCK = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FREE   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_BUSY      = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PAGE_W-1:0] page_number;
        logic [FI_W-1:0]   frame_index;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FI_W-1:0]   result_frame;
        logic              evicted;
        logic [PAGE_W-1:0] victim_page;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic clear;   // write one cleared entry of the flag table
        logic load;    // capture the input transfer
        logic rd;      // read the flag and tag tables
        logic commit;  // apply the evaluated step
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic final_step;
        logic out_free;
    } t_stat;

endpackage

### src/cfa_ctrl.sv
// ----------------------------------------------------------------------------
// cfa_ctrl
// Sequencer: clearing pass, input capture, and read/evaluate steps per frame.
// ----------------------------------------------------------------------------
module cfa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cfa_pkg::t_stat i_stat,
    output cfa_pkg::t_cmd  o_cmd
);
    import cfa_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL
    } t_state;

    t_state r_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd     = (r_state == S_READ);
        o_cmd.commit = (r_state == S_EVAL) && (!i_stat.final_step || i_stat.out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    // hold a finished result until the output slot frees up
                    if (!i_stat.final_step) begin
                        r_state <= S_READ;
                    end else if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_stat.clr_last) |=> (r_state == S_IDLE))
        else $error("clearing pass did not hand over to idle");

    a_scan_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && !i_stat.final_step) |=> (r_state == S_READ))
        else $error("scan step did not return to read");

endmodule

### src/cfa_dp.sv
// ----------------------------------------------------------------------------
// cfa_dp
// Frame tables, clock hand, scan counters and result register.
// ----------------------------------------------------------------------------
module cfa_dp #(
    parameter int FRAMES    = 256,
    parameter int PAGE_BITS = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cfa_pkg::CFG_W-1:0] i_cfg_wdata,
    input  cfa_pkg::t_in_item         i_in_data,
    input  cfa_pkg::t_cmd             i_cmd,
    output cfa_pkg::t_stat            o_stat,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output cfa_pkg::t_out_item        o_out_data
);
    import cfa_pkg::*;

    localparam int IDX_W = $clog2(FRAMES);
    localparam int N_W   = IDX_W + 1;
    localparam int S_W   = N_W + 1;
    localparam int CMP_W = (N_W > CFG_W) ? N_W : CFG_W;
    localparam int FC_W  = (N_W > FI_W) ? N_W : FI_W;
    localparam int VP_W  = (PAGE_BITS > PAGE_W) ? PAGE_BITS : PAGE_W;

    typedef struct packed {
        logic occ;
        logic acc;
        logic lck;
    } t_flags;

    t_flags                 r_flags_mem [FRAMES];
    logic [PAGE_BITS-1:0]   r_tag_mem   [FRAMES];

    logic [CFG_W-1:0]       r_cfg;
    logic [IDX_W-1:0]       r_hand;
    logic [IDX_W-1:0]       r_clr_idx;
    logic [IDX_W-1:0]       r_cur;
    logic [S_W-1:0]         r_steps;
    t_in_item               r_item;
    t_flags                 r_fq;
    logic [PAGE_BITS-1:0]   r_tq;
    logic [PAGE_BITS-1:0]   r_page_q;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic [CMP_W-1:0]       cfg_ext;
    logic [N_W-1:0]         n;
    logic [FC_W-1:0]        fi_ext;
    logic [IDX_W-1:0]       fi_addr;
    logic                   fi_out_of_range;
    logic                   is_alloc;
    logic [IDX_W-1:0]       acc_addr;
    logic [N_W-1:0]         cur_p1;
    logic [IDX_W-1:0]       nxt;
    logic [S_W-1:0]         steps_p1;
    logic                   scan_last;
    logic [FC_W-1:0]        cur_ext;
    logic [VP_W-1:0]        tag_ext;
    logic [VP_W-1:0]        page_ext;
    logic [IDX_W-1:0]       start_idx;

    logic                   e_final;
    logic [STAT_W-1:0]      e_status;
    logic [FI_W-1:0]        e_frame;
    logic                   e_evict;
    logic [PAGE_W-1:0]      e_victim;
    logic                   e_fwr;
    t_flags                 e_fdata;
    logic                   e_twr;
    logic                   e_hand_upd;

    // active frame count: zero acts as one, clamp to table size
    always_comb begin
        cfg_ext = CMP_W'(r_cfg);
        if (cfg_ext == '0) begin
            n = N_W'(1);
        end else if (cfg_ext > CMP_W'(FRAMES)) begin
            n = N_W'(FRAMES);
        end else begin
            n = cfg_ext[N_W-1:0];
        end
    end

    assign fi_ext          = FC_W'(r_item.frame_index);
    assign fi_addr         = fi_ext[IDX_W-1:0];
    assign fi_out_of_range = (fi_ext >= FC_W'(n));
    assign is_alloc        = (r_item.action == ACT_ALLOC);
    assign acc_addr        = is_alloc ? r_cur : fi_addr;
    assign cur_p1          = N_W'(r_cur) + N_W'(1);
    assign nxt             = (cur_p1 >= n) ? '0 : cur_p1[IDX_W-1:0];
    assign steps_p1        = r_steps + S_W'(1);
    assign scan_last       = (steps_p1 == {n, 1'b0});
    assign cur_ext         = FC_W'(r_cur);
    assign tag_ext         = VP_W'(r_tq);
    assign page_ext        = VP_W'(i_in_data.page_number);
    assign start_idx       = (N_W'(r_hand) >= n) ? '0 : r_hand;

    always_comb begin
        e_final    = 1'b0;
        e_status   = ST_OK;
        e_frame    = r_item.frame_index;
        e_evict    = 1'b0;
        e_victim   = '0;
        e_fwr      = 1'b0;
        e_fdata    = r_fq;
        e_twr      = 1'b0;
        e_hand_upd = 1'b0;
        priority if (is_alloc) begin
            if (!r_fq.occ && r_fq.lck) begin
                // free but pinned: step past it and answer busy
                e_final    = 1'b1;
                e_status   = ST_BUSY;
                e_hand_upd = 1'b1;
            end else if (!r_fq.occ || (!r_fq.acc && !r_fq.lck)) begin
                e_final    = 1'b1;
                e_frame    = cur_ext[FI_W-1:0];
                e_evict    = r_fq.occ;
                e_victim   = r_fq.occ ? tag_ext[PAGE_W-1:0] : '0;
                e_fwr      = 1'b1;
                e_fdata    = '{occ: 1'b1, acc: 1'b0, lck: 1'b1};
                e_twr      = 1'b1;
                e_hand_upd = 1'b1;
            end else begin
                // second chance: drop the accessed bit
                if (r_fq.acc) begin
                    e_fwr       = 1'b1;
                    e_fdata.acc = 1'b0;
                end
                if (scan_last) begin
                    e_final    = 1'b1;
                    e_status   = ST_EXHAUSTED;
                    e_hand_upd = 1'b1;
                end
            end
        end else if (r_item.action > ACT_FREE || fi_out_of_range) begin
            e_final  = 1'b1;
            e_status = ST_BUSY;
        end else begin
            e_final = 1'b1;
            unique case (r_item.action)
                ACT_TOUCH: begin
                    e_fwr       = 1'b1;
                    e_fdata.acc = 1'b1;
                end
                ACT_LOCK: begin
                    if (r_fq.lck) begin
                        e_status = ST_BUSY;
                    end else begin
                        e_fwr       = 1'b1;
                        e_fdata.lck = 1'b1;
                    end
                end
                ACT_UNLOCK: begin
                    if (!r_fq.lck) begin
                        e_status = ST_BUSY;
                    end else begin
                        e_fwr       = 1'b1;
                        e_fdata.lck = 1'b0;
                    end
                end
                default: begin
                    if (!r_fq.lck) begin
                        e_status = ST_BUSY;
                    end else begin
                        e_fwr   = 1'b1;
                        e_fdata = '{occ: 1'b0, acc: 1'b0, lck: 1'b0};
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_stat.clr_last   = (r_clr_idx == IDX_W'(FRAMES - 1));
        o_stat.final_step = e_final;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_hand      <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (i_cmd.commit && e_hand_upd) begin
                r_hand <= nxt;
            end
            if (i_cmd.commit && e_final) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_in_data;
            r_cur   <= start_idx;
            r_steps <= '0;
        end else if (i_cmd.commit && !e_final) begin
            r_cur   <= nxt;
            r_steps <= steps_p1;
        end
        if (i_cmd.commit && e_final) begin
            r_out.status       <= e_status;
            r_out.result_frame <= e_frame;
            r_out.evicted      <= e_evict;
            r_out.victim_page  <= e_victim;
        end
    end

    // flag table: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_flags_mem[r_clr_idx] <= '{occ: 1'b0, acc: 1'b0, lck: 1'b0};
        end else if (i_cmd.commit && e_fwr) begin
            r_flags_mem[acc_addr] <= e_fdata;
        end
        if (i_cmd.rd) begin
            r_fq <= r_flags_mem[acc_addr];
        end
    end

    // page tag table, never cleared
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && e_twr) begin
            r_tag_mem[r_cur] <= r_page_q;
        end
        if (i_cmd.rd) begin
            r_tq <= r_tag_mem[acc_addr];
        end
    end

    // hold the page in its own register until the grant
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page_q <= page_ext[PAGE_BITS-1:0];
        end
    end

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && e_final) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    a_out_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && e_final) |=> o_out_valid)
        else $error("finished step did not raise output valid");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd && is_alloc) |-> (N_W'(r_cur) < n))
        else $error("scan index beyond active frame count");

endmodule

### src/clock_frame_allocator.sv
// ----------------------------------------------------------------------------
// clock_frame_allocator
// Frame table with clock (second-chance) replacement and pin control.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  in       | i_in_valid, o_in_ready, i_in_data     | request
//  out      | o_out_valid, i_out_ready, o_out_data  | result
//  cfg      | i_cfg_we, i_cfg_wdata                 | frames_in_use write
//
//  After reset a clearing pass zeroes the flag table; no request is taken
//  until it ends. Touch, lock, unlock and free are one read and one evaluate.
//  An alloc visits at most twice the active count of frames, each with one read
//  and one evaluate on the flag table. A new request is taken while a result
//  waits in the output register; the last evaluate of the next request stalls
//  until that result transfers.
// ----------------------------------------------------------------------------
module clock_frame_allocator #(
    parameter int FRAMES    = 256,
    parameter int PAGE_BITS = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cfa_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  cfa_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output cfa_pkg::t_out_item        o_out_data
);
    import cfa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cfa_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
